>>> src/vector_to_yaw_pitch_core_macros.svh
// assertion macros used by the checker file
`ifndef VECTOR_TO_YAW_PITCH_CORE_MACROS_SVH
`define VECTOR_TO_YAW_PITCH_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define VTYP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define VTYP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/vtyp_pkg.sv
// shared types, constants and functions for the vector to yaw/pitch core
`timescale 1ns / 1ps
package vtyp_pkg;

    localparam int CORDIC_STEPS    = 24;
    localparam int ANGLE_FRAC_BITS = 16;

    localparam int IN_W       = 32;
    localparam int YAW_W      = 25;
    localparam int PITCH_W    = 24;
    localparam int DW         = 64;
    localparam int WORK_FRAC  = ANGLE_FRAC_BITS + 8;
    localparam int ACC_W      = WORK_FRAC + 11;
    localparam int STEP_W     = 5;
    localparam int SH_W       = 6;
    localparam int MSB_W      = 5;
    localparam int GAIN_W     = 30;
    localparam int PROD_W     = IN_W + GAIN_W;
    localparam int NORM_TOP   = 58;
    localparam int PITCH_REF  = 28;
    localparam int PIPE_DEPTH = 2 * CORDIC_STEPS + 6;
    localparam int CNT_W      = $clog2(PIPE_DEPTH + 1);

    localparam logic signed [GAIN_W-1:0] GAIN_Q28 = 30'sd442048841;
    localparam logic signed [YAW_W-1:0]  YAW_LIM   = 25'sd11796480;
    localparam logic signed [YAW_W-1:0]  PITCH_LIM = 25'sd5898240;

    // +-180 degrees in accumulator units
    localparam logic signed [ACC_W-1:0] HALF_TURN = ACC_W'(180) <<< WORK_FRAC;

    localparam int ANG_SH = 32 - WORK_FRAC;
    localparam logic [63:0] ANG_HALF = (64'd1 << ANG_SH) >> 1;
    localparam int RND_SH = WORK_FRAC - 16;
    localparam logic signed [ACC_W:0] RND_HALF = (ACC_W+1)'((64'd1 << RND_SH) >> 1);

    // atan(2^-i) in degrees, units of 2^-32 degree
    localparam logic [63:0] ATAN_Q32 [32] = '{
        64'd193273528320, 64'd114096026022, 64'd60285206653, 64'd30601712202,
        64'd15360239180,  64'd7687607525,   64'd3844741810,  64'd1922488225,
        64'd961258780,    64'd480631223,    64'd240315841,   64'd120157949,
        64'd60078978,     64'd30039489,     64'd15019745,    64'd7509872,
        64'd3754936,      64'd1877468,      64'd938734,      64'd469367,
        64'd234684,       64'd117342,       64'd58671,       64'd29335,
        64'd14668,        64'd7334,         64'd3667,        64'd1833,
        64'd917,          64'd458,          64'd229,         64'd115
    };

    typedef struct packed {
        logic signed [DW-1:0]    b;        // gain-scaled -z for the pitch pass
        logic [SH_W-1:0]         shift;    // normalizing left shift
        logic                    special;  // x and y both zero
        logic                    z_pos;
        logic signed [YAW_W-1:0] yaw;
    } t_side;

    typedef struct packed {
        logic signed [DW-1:0]    x;
        logic signed [DW-1:0]    y;
        logic signed [ACC_W-1:0] acc;
        t_side                   side;
    } t_cell;

    function automatic logic signed [ACC_W-1:0] micro_angle(input logic [STEP_W-1:0] step);
        logic [63:0] t;
        t = (ATAN_Q32[step] + ANG_HALF) >> ANG_SH;
        return $signed(ACC_W'(t));
    endfunction

    // round half up to Q9.16, then clamp to +-lim
    function automatic logic signed [YAW_W-1:0] round_angle(
        input logic signed [ACC_W-1:0] acc,
        input logic signed [YAW_W-1:0] lim
    );
        logic signed [ACC_W:0] r;
        logic signed [ACC_W:0] l;
        r = ((ACC_W+1)'(acc) + RND_HALF) >>> RND_SH;
        l = (ACC_W+1)'(lim);
        if (r > l) begin
            r = l;
        end
        if (r < -l) begin
            r = -l;
        end
        return YAW_W'(r);
    endfunction

endpackage

>>> src/vtyp_dir_if.sv
// input channel: direction vector transaction
`timescale 1ns / 1ps
interface vtyp_dir_if;
    import vtyp_pkg::*;

    logic                   valid;
    logic                   ready;
    logic signed [IN_W-1:0] dir_x;
    logic signed [IN_W-1:0] dir_y;
    logic signed [IN_W-1:0] dir_z;

    modport source (output valid, dir_x, dir_y, dir_z, input ready);
    modport sink   (input valid, dir_x, dir_y, dir_z, output ready);
endinterface

>>> src/vtyp_ang_if.sv
// output channel: yaw and pitch transaction
`timescale 1ns / 1ps
interface vtyp_ang_if;
    import vtyp_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [YAW_W-1:0]   yaw_deg;
    logic signed [PITCH_W-1:0] pitch_deg;

    modport source (output valid, yaw_deg, pitch_deg, input ready);
    modport sink   (input valid, yaw_deg, pitch_deg, output ready);
endinterface

>>> src/vtyp_cell.sv
// one cordic vectoring micro-rotation with its own pipeline register
`timescale 1ns / 1ps
module vtyp_cell (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [vtyp_pkg::STEP_W-1:0]    i_step,
    input  logic                           i_valid,
    input  vtyp_pkg::t_cell                i_data,
    input  logic                           i_stall,
    output logic                           o_stall,
    output logic                           o_valid,
    output vtyp_pkg::t_cell                o_data
);
    import vtyp_pkg::*;

    logic                 r_vld;
    t_cell                r_dat;
    t_cell                n_dat;
    logic                 w_en;
    logic signed [DW-1:0] w_dx;
    logic signed [DW-1:0] w_dy;
    logic signed [ACC_W-1:0] w_da;

    always_comb begin
        w_en    = !r_vld || !i_stall;
        o_stall = r_vld && i_stall;
        w_dx    = i_data.y >>> i_step;
        w_dy    = i_data.x >>> i_step;
        w_da    = micro_angle(i_step);
        n_dat   = i_data;
        // rotate toward the x axis
        if (i_data.y[DW-1]) begin
            n_dat.x   = i_data.x - w_dx;
            n_dat.y   = i_data.y + w_dy;
            n_dat.acc = i_data.acc - w_da;
        end else begin
            n_dat.x   = i_data.x + w_dx;
            n_dat.y   = i_data.y - w_dy;
            n_dat.acc = i_data.acc + w_da;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_en) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && i_valid) begin
            r_dat <= n_dat;
        end
    end

    assign o_valid = r_vld;
    assign o_data  = r_dat;
endmodule

>>> src/vtyp_front.sv
// front end: half-turn fold, gain multiply, leading-one search, normalizing shift
`timescale 1ns / 1ps
module vtyp_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic signed [vtyp_pkg::IN_W-1:0]  i_dir_x,
    input  logic signed [vtyp_pkg::IN_W-1:0]  i_dir_y,
    input  logic signed [vtyp_pkg::IN_W-1:0]  i_dir_z,
    input  logic                              i_stall,
    output logic                              o_stall,
    output logic                              o_valid,
    output vtyp_pkg::t_cell                   o_data
);
    import vtyp_pkg::*;

    logic [3:0] r_vld;
    logic [4:0] w_stall;
    logic [3:0] w_en;

    // stage 0
    logic signed [IN_W:0]     r0_x, r0_y, n0_x, n0_y;
    logic signed [ACC_W-1:0]  r0_acc, n0_acc;
    logic signed [PROD_W-1:0] r0_prod, n0_prod;
    logic                     r0_special, n0_special, r0_zpos, n0_zpos;
    // stage 1
    logic signed [IN_W:0]     r1_x, r1_y, w1_ay;
    logic [IN_W-1:0]          r1_m, n1_m;
    logic signed [DW-1:0]     r1_b, n1_b;
    logic signed [ACC_W-1:0]  r1_acc;
    logic                     r1_special, r1_zpos;
    // stage 2
    logic signed [IN_W:0]     r2_x, r2_y;
    logic [SH_W-1:0]          r2_s, n2_s;
    logic [MSB_W-1:0]         w2_msb;
    logic signed [DW-1:0]     r2_b;
    logic signed [ACC_W-1:0]  r2_acc;
    logic                     r2_special, r2_zpos;
    // stage 3
    t_cell                    r3_dat, n3_dat;

    always_comb begin
        w_stall[4] = i_stall;
        for (int k = 3; k >= 0; k--) begin
            w_stall[k] = r_vld[k] && w_stall[k+1];
            w_en[k]    = !r_vld[k] || !w_stall[k+1];
        end
        o_stall = w_stall[0];
    end

    always_comb begin
        n0_special = (i_dir_x == '0) && (i_dir_y == '0);
        n0_zpos    = (i_dir_z > 0);
        n0_prod    = i_dir_z * GAIN_Q28;
        if (i_dir_x[IN_W-1]) begin
            n0_x   = -(IN_W+1)'(i_dir_x);
            n0_y   = -(IN_W+1)'(i_dir_y);
            n0_acc = i_dir_y[IN_W-1] ? -HALF_TURN : HALF_TURN;
        end else begin
            n0_x   = (IN_W+1)'(i_dir_x);
            n0_y   = (IN_W+1)'(i_dir_y);
            n0_acc = '0;
        end
    end

    always_comb begin
        w1_ay = r0_y[IN_W] ? -r0_y : r0_y;
        n1_m  = (r0_x > w1_ay) ? IN_W'(r0_x) : IN_W'(w1_ay);
        n1_b  = -DW'(r0_prod);
    end

    always_comb begin
        w2_msb = '0;
        for (int i = 0; i < IN_W; i++) begin
            if (r1_m[i]) begin
                w2_msb = MSB_W'(i);
            end
        end
        n2_s = SH_W'(NORM_TOP) - SH_W'(w2_msb);
    end

    always_comb begin
        n3_dat.x            = DW'(r2_x) <<< r2_s;
        n3_dat.y            = DW'(r2_y) <<< r2_s;
        n3_dat.acc          = r2_acc;
        n3_dat.side.b       = r2_b;
        n3_dat.side.shift   = r2_s;
        n3_dat.side.special = r2_special;
        n3_dat.side.z_pos   = r2_zpos;
        n3_dat.side.yaw     = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < 4; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0] && i_valid) begin
            r0_x       <= n0_x;
            r0_y       <= n0_y;
            r0_acc     <= n0_acc;
            r0_prod    <= n0_prod;
            r0_special <= n0_special;
            r0_zpos    <= n0_zpos;
        end
        if (w_en[1] && r_vld[0]) begin
            r1_x       <= r0_x;
            r1_y       <= r0_y;
            r1_m       <= n1_m;
            r1_b       <= n1_b;
            r1_acc     <= r0_acc;
            r1_special <= r0_special;
            r1_zpos    <= r0_zpos;
        end
        if (w_en[2] && r_vld[1]) begin
            r2_x       <= r1_x;
            r2_y       <= r1_y;
            r2_s       <= n2_s;
            r2_b       <= r1_b;
            r2_acc     <= r1_acc;
            r2_special <= r1_special;
            r2_zpos    <= r1_zpos;
        end
        if (w_en[3] && r_vld[2]) begin
            r3_dat <= n3_dat;
        end
    end

    assign o_valid = r_vld[3];
    assign o_data  = r3_dat;
endmodule

>>> src/vtyp_mid.sv
// between the passes: yaw rounding and rescale of the magnitude for the pitch pass
`timescale 1ns / 1ps
module vtyp_mid (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  vtyp_pkg::t_cell i_data,
    input  logic            i_stall,
    output logic            o_stall,
    output logic            o_valid,
    output vtyp_pkg::t_cell o_data
);
    import vtyp_pkg::*;

    logic  r_vld;
    t_cell r_dat;
    t_cell n_dat;
    logic  w_en;

    always_comb begin
        w_en    = !r_vld || !i_stall;
        o_stall = r_vld && i_stall;
        n_dat   = i_data;
        // bring the magnitude to 2^28 units of the input lsb
        if (i_data.side.shift >= SH_W'(PITCH_REF)) begin
            n_dat.x = i_data.x >>> (i_data.side.shift - SH_W'(PITCH_REF));
        end else begin
            n_dat.x = i_data.x <<< 1;
        end
        n_dat.y        = i_data.side.b;
        n_dat.acc      = '0;
        n_dat.side.yaw = round_angle(i_data.acc, YAW_LIM);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_en) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && i_valid) begin
            r_dat <= n_dat;
        end
    end

    assign o_valid = r_vld;
    assign o_data  = r_dat;
endmodule

>>> src/vtyp_back.sv
// output register: pitch rounding and the zero x/y override
`timescale 1ns / 1ps
module vtyp_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  vtyp_pkg::t_cell                     i_data,
    input  logic                                i_ready,
    output logic                                o_stall,
    output logic                                o_valid,
    output logic signed [vtyp_pkg::YAW_W-1:0]   o_yaw,
    output logic signed [vtyp_pkg::PITCH_W-1:0] o_pitch
);
    import vtyp_pkg::*;

    logic                      r_vld;
    logic                      w_en;
    logic signed [YAW_W-1:0]   r_yaw, n_yaw;
    logic signed [PITCH_W-1:0] r_pitch, n_pitch;

    always_comb begin
        w_en    = !r_vld || i_ready;
        o_stall = r_vld && !i_ready;
        if (i_data.side.special) begin
            n_yaw   = '0;
            n_pitch = i_data.side.z_pos ? -PITCH_W'(PITCH_LIM) : PITCH_W'(PITCH_LIM);
        end else begin
            n_yaw   = i_data.side.yaw;
            n_pitch = PITCH_W'(round_angle(i_data.acc, PITCH_LIM));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_en) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && i_valid) begin
            r_yaw   <= n_yaw;
            r_pitch <= n_pitch;
        end
    end

    assign o_valid = r_vld;
    assign o_yaw   = r_yaw;
    assign o_pitch = r_pitch;
endmodule

>>> src/vector_to_yaw_pitch_core.sv
// Direction vector to yaw/pitch converter. Takes a signed Q16.16 vector
// (dir_x, dir_y, dir_z) and returns yaw = atan2(y, x) in [-180, 180] and
// pitch = atan2(-z, sqrt(x^2 + y^2)) in [-90, 90] degrees, yaw signed Q9.16
// and pitch signed Q8.16, rounded half up and clamped; positive pitch points
// down. When x and y are both zero, yaw is 0 and pitch is -90 for z > 0, else
// +90. The datapath is a fully pipelined CORDIC: a four-stage front end, a row
// of CORDIC_STEPS cells for the yaw pass, one rescale stage, a second row of
// CORDIC_STEPS cells for the pitch pass and an output register, one
// micro-rotation per cell. One transaction is accepted every cycle while the
// pipe is not stalled. Every stage has its own valid bit and only stalls when
// the stage ahead of it is full and stalled, so bubbles close up and new
// transactions keep entering while a result waits. No reset-time sweep; the
// pipe is ready as soon as reset is released.
`timescale 1ns / 1ps
module vector_to_yaw_pitch_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    vtyp_dir_if.sink   i_dir,
    vtyp_ang_if.source o_ang
);
    import vtyp_pkg::*;

    // yaw pass cell row
    logic [CORDIC_STEPS:0] w_c1_vld;
    logic [CORDIC_STEPS:0] w_c1_stl;
    t_cell                 w_c1_dat [CORDIC_STEPS+1];
    // pitch pass cell row
    logic [CORDIC_STEPS:0] w_c2_vld;
    logic [CORDIC_STEPS:0] w_c2_stl;
    t_cell                 w_c2_dat [CORDIC_STEPS+1];

    logic w_front_stall;

    // fold to the right half plane, normalize, scale -z by the cordic gain
    vtyp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_dir.valid),
        .i_dir_x (i_dir.dir_x),
        .i_dir_y (i_dir.dir_y),
        .i_dir_z (i_dir.dir_z),
        .i_stall (w_c1_stl[0]),
        .o_stall (w_front_stall),
        .o_valid (w_c1_vld[0]),
        .o_data  (w_c1_dat[0])
    );

    assign i_dir.ready = !w_front_stall;

    // yaw pass: rotate (x, y) onto the x axis
    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_yaw
        vtyp_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_step  (STEP_W'(k)),
            .i_valid (w_c1_vld[k]),
            .i_data  (w_c1_dat[k]),
            .i_stall (w_c1_stl[k+1]),
            .o_stall (w_c1_stl[k]),
            .o_valid (w_c1_vld[k+1]),
            .o_data  (w_c1_dat[k+1])
        );
    end

    // yaw is final here; the gain-carrying magnitude feeds the pitch pass
    vtyp_mid u_mid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_c1_vld[CORDIC_STEPS]),
        .i_data  (w_c1_dat[CORDIC_STEPS]),
        .i_stall (w_c2_stl[0]),
        .o_stall (w_c1_stl[CORDIC_STEPS]),
        .o_valid (w_c2_vld[0]),
        .o_data  (w_c2_dat[0])
    );

    // pitch pass: gain cancels between magnitude and scaled -z
    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_pitch
        vtyp_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_step  (STEP_W'(k)),
            .i_valid (w_c2_vld[k]),
            .i_data  (w_c2_dat[k]),
            .i_stall (w_c2_stl[k+1]),
            .o_stall (w_c2_stl[k]),
            .o_valid (w_c2_vld[k+1]),
            .o_data  (w_c2_dat[k+1])
        );
    end

    // output register, holds a result until the sink takes it
    vtyp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_c2_vld[CORDIC_STEPS]),
        .i_data  (w_c2_dat[CORDIC_STEPS]),
        .i_ready (o_ang.ready),
        .o_stall (w_c2_stl[CORDIC_STEPS]),
        .o_valid (o_ang.valid),
        .o_yaw   (o_ang.yaw_deg),
        .o_pitch (o_ang.pitch_deg)
    );
endmodule

>>> src/vtyp_checker.sv
// port-level checks for the vector to yaw/pitch core, bound to the top level
`timescale 1ns / 1ps
`include "vector_to_yaw_pitch_core_macros.svh"
module vtyp_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                i_in_ready,
    input logic                                i_out_valid,
    input logic                                i_out_ready,
    input logic signed [vtyp_pkg::YAW_W-1:0]   i_yaw,
    input logic signed [vtyp_pkg::PITCH_W-1:0] i_pitch
);
    import vtyp_pkg::*;

    logic [CNT_W-1:0] r_in_flight;
    logic [CNT_W-1:0] n_in_flight;
    logic             w_in_acc;
    logic             w_out_acc;

    always_comb begin
        w_in_acc    = i_in_valid && i_in_ready;
        w_out_acc   = i_out_valid && i_out_ready;
        n_in_flight = r_in_flight + CNT_W'(w_in_acc) - CNT_W'(w_out_acc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_flight <= '0;
        end else begin
            r_in_flight <= n_in_flight;
        end
    end

    // a result never shows up without an accepted transaction behind it
    `VTYP_ASSERT_IMP(a_no_spurious_out, i_clk, i_rst_n, i_out_valid, r_in_flight != '0, "vtyp: result without a pending transaction")
    // the pipe never holds more than its depth
    `VTYP_ASSERT_IMP(a_depth_bound, i_clk, i_rst_n, w_in_acc, r_in_flight <= CNT_W'(PIPE_DEPTH), "vtyp: more transactions in flight than stages")
    `VTYP_ASSERT_IMP(a_yaw_range, i_clk, i_rst_n, i_out_valid, (i_yaw <= YAW_LIM) && (i_yaw >= -YAW_LIM), "vtyp: yaw out of range")
    `VTYP_ASSERT_IMP(a_pitch_range, i_clk, i_rst_n, i_out_valid, (i_pitch <= PITCH_W'(PITCH_LIM)) && (i_pitch >= -PITCH_W'(PITCH_LIM)), "vtyp: pitch out of range")
    `VTYP_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_yaw) && $stable(i_pitch), "vtyp: stalled result changed")
endmodule

bind vector_to_yaw_pitch_core vtyp_checker u_vtyp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_dir.valid),
    .i_in_ready  (i_dir.ready),
    .i_out_valid (o_ang.valid),
    .i_out_ready (o_ang.ready),
    .i_yaw       (o_ang.yaw_deg),
    .i_pitch     (o_ang.pitch_deg)
);
